// ===== sv/agcp_pkg.sv =====
// Shared types, character codes, sizes and helpers for the ASCII gain command parser.
// Used by every module of the block; depends on nothing.
`default_nettype none

package agcp_pkg;

  // Frame and number format limits
  localparam int FRAME_BYTES     = 64;
  localparam int MAX_FRAC_DIGITS = 5;

  localparam int IDX_W     = $clog2(FRAME_BYTES);
  localparam int DEN_SCALE = 10 ** MAX_FRAC_DIGITS;
  localparam int FRAC_W    = $clog2(DEN_SCALE);
  localparam int ND_W      = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int INT_W     = 16;
  localparam int VAL_W     = 32;
  localparam int TGT_W     = 4;

  // Fraction conversion: padded fraction * 2^17 + 10^N, divided by 2 * 10^N,
  // done as a shift by N+1 and a division by 5^N through a reciprocal.
  localparam int          NUM_W     = FRAC_W + INT_W + 2;
  localparam int          SHIFT_DEN = MAX_FRAC_DIGITS + 1;
  localparam longint      FIVE_POW  = 5 ** MAX_FRAC_DIGITS;
  localparam int          X_W       = $clog2(FIVE_POW * 65536 + 1);
  localparam int          RECIP_SH  = X_W + $clog2(FIVE_POW);
  localparam int          RECIP_W   = X_W + 1;
  localparam logic [63:0] RECIP     = (64'd1 << RECIP_SH) / FIVE_POW;
  localparam int          Q_W       = INT_W + 1;

  // Queue between parser and converter
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;

  // Gain selector codes
  localparam logic [1:0]       SEL_NONE    = 2'd3;
  localparam logic [TGT_W-1:0] TARGET_NONE = 4'd9;

  // One finished frame handed from parser to converter
  typedef struct packed {
    logic [TGT_W-1:0]  target;
    logic              format_ok;
    logic              negative;
    logic [INT_W-1:0]  int_part;
    logic [FRAC_W-1:0] frac_part;
    logic [ND_W-1:0]   frac_digits;
  } entry_t;

  // Fields that ride along the converter pipeline
  typedef struct packed {
    logic [TGT_W-1:0] target;
    logic             format_ok;
    logic             negative;
    logic [INT_W-1:0] int_part;
  } meta_t;

  function automatic logic [1:0] decode_kind(input logic [7:0] ch);
    logic [1:0] k;
    case (ch)
      CH_P:    k = 2'd0;
      CH_I:    k = 2'd1;
      CH_D:    k = 2'd2;
      default: k = SEL_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] decode_loop(input logic [7:0] ch);
    logic [1:0] l;
    case (ch)
      CH_1:    l = 2'd0;
      CH_2:    l = 2'd1;
      CH_3:    l = 2'd2;
      default: l = SEL_NONE;
    endcase
    return l;
  endfunction

  function automatic logic [TGT_W-1:0] make_target(input logic [1:0] kind,
                                                   input logic [1:0] loop_sel);
    logic [TGT_W-1:0] t;
    if (kind == SEL_NONE || loop_sel == SEL_NONE) begin
      t = TARGET_NONE;
    end else begin
      t = TGT_W'({2'b00, kind} * 4'd3 + {2'b00, loop_sel});
    end
    return t;
  endfunction

  // 10^(MAX_FRAC_DIGITS - nd): pads a fraction to the full digit count
  function automatic logic [FRAC_W-1:0] pad_scale(input logic [ND_W-1:0] nd);
    logic [FRAC_W-1:0] s;
    s = '0;
    if (int'(nd) <= MAX_FRAC_DIGITS) begin
      s = FRAC_W'(1);
      for (int k = 0; k < MAX_FRAC_DIGITS; k++) begin
        if (k >= int'(nd)) begin
          s = FRAC_W'(s * 10);
        end
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== sv/agcp_if.sv =====
// Handshake channels of the ASCII gain command parser: received bytes in, results out.
// Valid/ready with payload; no dependencies.
`default_nettype none

interface agcp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface agcp_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         target;
  logic signed [31:0] value;
  logic               format_ok;

  modport source (output valid, output target, output value, output format_ok, input ready);
  modport sink   (input valid, input target, input value, input format_ok, output ready);
endinterface

`default_nettype wire

// ===== sv/agcp_front.sv =====
// Byte parser of the ASCII gain command parser: tracks frame state, emits one entry per frame.
// Depends on agcp_pkg and agcp_byte_if.
`default_nettype none

module agcp_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  agcp_byte_if.sink             rx_i,
  output logic                  push_valid_o,
  output agcp_pkg::entry_t      push_o,
  input  wire logic             push_ready_i
);
  import agcp_pkg::*;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [1:0]        kind_q, kind_d, loop_q, loop_d;
  logic              seen_eq_q, seen_eq_d;
  logic              start_q, start_d;
  logic              neg_q, neg_d;
  logic              point_q, point_d;
  logic              bad_q, bad_d;
  logic [INT_W-1:0]  int_q, int_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [ND_W-1:0]   nd_q, nd_d;

  logic              take;
  logic [7:0]        b;
  logic              is_bang, is_eq, is_digit, last_byte, emit;
  logic [3:0]        digit;
  logic [1:0]        kind_eff, loop_eff;
  logic [INT_W+3:0]  int_mac;
  logic [FRAC_W+3:0] frac_mac;

  assign b        = rx_i.rx_byte;
  assign take     = rx_i.valid && rx_i.ready;
  assign is_bang  = (b == CH_BANG);
  assign is_eq    = (b == CH_EQ);
  assign is_digit = (b >= CH_0) && (b <= CH_9);
  assign digit    = 4'(b - CH_0);
  assign int_mac  = (INT_W + 4)'(int_q) * (INT_W + 4)'(10) + (INT_W + 4)'(digit);
  assign frac_mac = (FRAC_W + 4)'(frac_q) * (FRAC_W + 4)'(10) + (FRAC_W + 4)'(digit);

  // Bytes 0 and 1 pick the gain; use them right away when they land
  assign kind_eff  = (idx_q == '0) ? decode_kind(b) : kind_q;
  assign loop_eff  = (idx_q == IDX_W'(1)) ? decode_loop(b) : loop_q;
  assign last_byte = ((IDX_W + 1)'(idx_q) + (IDX_W + 1)'(1)) >= (IDX_W + 1)'(FRAME_BYTES);
  assign emit      = is_bang || last_byte;

  // Hold input while the queue is full
  assign rx_i.ready   = push_ready_i;
  assign push_valid_o = take && emit;

  always_comb begin
    push_o.target      = make_target(kind_eff, loop_eff);
    push_o.format_ok   = is_bang && seen_eq_q && !bad_q;
    push_o.negative    = neg_q;
    push_o.int_part    = int_q;
    push_o.frac_part   = frac_q;
    push_o.frac_digits = nd_q;
  end

  // Next frame state for one byte
  always_comb begin
    idx_d     = idx_q;
    kind_d    = kind_q;
    loop_d    = loop_q;
    seen_eq_d = seen_eq_q;
    start_d   = start_q;
    neg_d     = neg_q;
    point_d   = point_q;
    bad_d     = bad_q;
    int_d     = int_q;
    frac_d    = frac_q;
    nd_d      = nd_q;

    if (emit) begin
      // Start a new frame
      idx_d     = '0;
      kind_d    = SEL_NONE;
      loop_d    = SEL_NONE;
      seen_eq_d = 1'b0;
      start_d   = 1'b0;
      neg_d     = 1'b0;
      point_d   = 1'b0;
      bad_d     = 1'b0;
      int_d     = '0;
      frac_d    = '0;
      nd_d      = '0;
    end else begin
      idx_d  = idx_q + IDX_W'(1);
      kind_d = kind_eff;
      loop_d = loop_eff;
      if (is_eq) begin
        // Restart the value
        seen_eq_d = 1'b1;
        start_d   = 1'b1;
        neg_d     = 1'b0;
        point_d   = 1'b0;
        bad_d     = 1'b0;
        int_d     = '0;
        frac_d    = '0;
        nd_d      = '0;
      end else if (seen_eq_q) begin
        start_d = 1'b0;
        if (b == CH_MINUS && start_q) begin
          neg_d = 1'b1;
        end else if (b == CH_POINT) begin
          if (point_q) begin
            bad_d = 1'b1;
          end else begin
            point_d = 1'b1;
          end
        end else if (is_digit) begin
          if (point_q) begin
            // Drop digits past the kept precision
            if (int'(nd_q) < MAX_FRAC_DIGITS) begin
              frac_d = frac_mac[FRAC_W-1:0];
              nd_d   = nd_q + ND_W'(1);
            end
          end else if (int_mac > (INT_W + 4)'(16'hFFFF)) begin
            int_d = '1;
          end else begin
            int_d = int_mac[INT_W-1:0];
          end
        end else begin
          bad_d = 1'b1;
        end
      end
    end
  end

  // Advance state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      kind_q    <= SEL_NONE;
      loop_q    <= SEL_NONE;
      seen_eq_q <= 1'b0;
      start_q   <= 1'b0;
      neg_q     <= 1'b0;
      point_q   <= 1'b0;
      bad_q     <= 1'b0;
      int_q     <= '0;
      frac_q    <= '0;
      nd_q      <= '0;
    end else if (take) begin
      idx_q     <= idx_d;
      kind_q    <= kind_d;
      loop_q    <= loop_d;
      seen_eq_q <= seen_eq_d;
      start_q   <= start_d;
      neg_q     <= neg_d;
      point_q   <= point_d;
      bad_q     <= bad_d;
      int_q     <= int_d;
      frac_q    <= frac_d;
      nd_q      <= nd_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_restarts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && emit) |=> (idx_q == '0 && !seen_eq_q))
    else $error("frame state not cleared after an emitted item");
  a_ok_needs_equals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_valid_o && push_o.format_ok) |-> (seen_eq_q && is_bang))
    else $error("good item pushed without equals sign or terminator");
`endif

endmodule

`default_nettype wire

// ===== sv/agcp_queue.sv =====
// Short queue between parser and converter so each side can stall on its own.
// Depends on agcp_pkg.
`default_nettype none

module agcp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  input  agcp_pkg::entry_t       push_i,
  output logic                   push_ready_o,
  output logic                   pop_valid_o,
  output agcp_pkg::entry_t       pop_o,
  input  wire logic              pop_ready_i
);
  import agcp_pkg::*;

  entry_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_o        = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (cnt_q == $past(cnt_q) + QCNT_W'(1)))
    else $error("queue count missed a push");
`endif

endmodule

`default_nettype wire

// ===== sv/agcp_back.sv =====
// Converter of the ASCII gain command parser: turns parsed digits into signed Q16.16.
// Four-stage pipeline ending in the output register; depends on agcp_pkg and agcp_res_if.
`default_nettype none

module agcp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pop_valid_i,
  input  agcp_pkg::entry_t       pop_i,
  output logic                   pop_ready_o,
  agcp_res_if.source             res_o
);
  import agcp_pkg::*;

  localparam logic [RECIP_W-1:0] RECIP_K = RECIP[RECIP_W-1:0];
  localparam logic [X_W-1:0]     FIVE_X  = X_W'(FIVE_POW);

  logic adv;

  // Stage 1: scaled numerator
  logic              s1_v_q;
  meta_t             s1_meta_q;
  logic [X_W-1:0]    s1_x_q;
  logic [2*FRAC_W-1:0] pad_prod;
  logic [NUM_W-1:0]  num;

  // Stage 2: quotient estimate
  logic                  s2_v_q;
  meta_t                 s2_meta_q;
  logic [X_W-1:0]        s2_x_q;
  logic [Q_W-1:0]        s2_q_q;
  logic [X_W+RECIP_W-1:0] recip_prod;

  // Stage 3: corrected fraction
  logic              s3_v_q;
  meta_t             s3_meta_q;
  logic [Q_W-1:0]    s3_frac_q;
  logic [X_W+Q_W-1:0] back_prod;
  logic [X_W-1:0]    rem;

  // Output stage: magnitude, saturation, sign
  logic               out_v_q;
  logic [TGT_W-1:0]   out_tgt_q;
  logic [VAL_W-1:0]   out_val_q;
  logic               out_ok_q;
  logic [VAL_W:0]     mag;
  logic [VAL_W:0]     mag_sat;
  logic [VAL_W-1:0]   val_d;

  // Move the whole pipeline unless the output is held
  assign adv         = !out_v_q || res_o.ready;
  assign pop_ready_o = adv;

  assign pad_prod   = (2 * FRAC_W)'(pop_i.frac_part) *
                      (2 * FRAC_W)'(pad_scale(pop_i.frac_digits));
  assign num        = NUM_W'({pad_prod[FRAC_W-1:0], {(INT_W + 1){1'b0}}}) +
                      NUM_W'(DEN_SCALE);
  assign recip_prod = (X_W + RECIP_W)'(s1_x_q) * (X_W + RECIP_W)'(RECIP_K);
  assign back_prod  = (X_W + Q_W)'(s2_q_q) * (X_W + Q_W)'(FIVE_X);
  assign rem        = s2_x_q - back_prod[X_W-1:0];

  always_comb begin
    mag = {1'b0, s3_meta_q.int_part, {INT_W{1'b0}}} + (VAL_W + 1)'(s3_frac_q);
    if (s3_meta_q.negative) begin
      mag_sat = (mag > (VAL_W + 1)'(33'h080000000)) ? (VAL_W + 1)'(33'h080000000) : mag;
      val_d   = VAL_W'(0) - mag_sat[VAL_W-1:0];
    end else begin
      mag_sat = (mag > (VAL_W + 1)'(33'h07FFFFFFF)) ? (VAL_W + 1)'(33'h07FFFFFFF) : mag;
      val_d   = mag_sat[VAL_W-1:0];
    end
    if (!s3_meta_q.format_ok) begin
      val_d = '0;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= pop_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_meta_q.target    <= pop_i.target;
      s1_meta_q.format_ok <= pop_i.format_ok;
      s1_meta_q.negative  <= pop_i.negative;
      s1_meta_q.int_part  <= pop_i.int_part;
      s1_x_q              <= X_W'(num >> SHIFT_DEN);

      s2_meta_q <= s1_meta_q;
      s2_x_q    <= s1_x_q;
      s2_q_q    <= Q_W'(recip_prod >> RECIP_SH);

      // Estimate may be one short: fix it with the remainder
      s3_meta_q <= s2_meta_q;
      s3_frac_q <= (rem >= FIVE_X) ? s2_q_q + Q_W'(1) : s2_q_q;

      out_tgt_q <= s3_meta_q.target;
      out_ok_q  <= s3_meta_q.format_ok;
      out_val_q <= val_d;
    end
  end

  assign res_o.valid     = out_v_q;
  assign res_o.target    = out_tgt_q;
  assign res_o.value     = out_val_q;
  assign res_o.format_ok = out_ok_q;

`ifndef SYNTHESIS
  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ok_q) |-> (out_val_q == '0))
    else $error("failed frame carries a nonzero value");
  a_target_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_tgt_q <= TARGET_NONE))
    else $error("target code out of range");
  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_v_q |-> (s3_frac_q <= Q_W'(17'h10000)))
    else $error("fraction conversion beyond one");
`endif

endmodule

`default_nettype wire

// ===== sv/ascii_gain_command_parser.sv =====
// Top level of the ASCII gain command parser: parser, queue and fixed-point converter.
// Depends on agcp_pkg, agcp_if, agcp_front, agcp_queue and agcp_back.
`default_nettype none

// Feeds on received command bytes such as "P2=-1.25!", one byte per cycle with no gaps
// needed between bytes. Each '!' (or a frame that runs to FRAME_BYTES bytes) gives one
// result: the gain target 0..8 (9 for none), the value as signed Q16.16 and a format flag;
// a bad frame gives value 0 and the flag clear. Once the terminating byte is accepted, the
// result passes through the queue and the four-stage conversion pipeline (padding multiply,
// reciprocal multiply, remainder correction, saturate and sign). A two-entry queue sits
// between the parser and the converter, so a stalled result stalls input only once it fills.
module ascii_gain_command_parser (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  agcp_byte_if.sink   rx_i,
  agcp_res_if.source  res_o
);
  import agcp_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  agcp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .push_valid_o (push_valid),
    .push_o       (push_entry),
    .push_ready_i (push_ready)
  );

  agcp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_i       (push_entry),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_o        (pop_entry),
    .pop_ready_i  (pop_ready)
  );

  agcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_i       (pop_entry),
    .pop_ready_o (pop_ready),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== dv/ascii_gain_command_parser_tb.sv =====
// Testbench for the ASCII gain command parser: sends command frames byte by byte and checks
// every result against an in-bench model of the parser. Needs agcp_pkg, agcp_if and the RTL.

import agcp_pkg::*;

// One parsed command as the block reports it
typedef struct {
  logic [3:0]         target;
  logic signed [31:0] value;
  logic               format_ok;
} gain_cmd_t;

// Tracks the parser state for every accepted byte and checks the commands that come out
class gain_cmd_scoreboard;
  logic [6:0]  byte_idx    = '0;
  logic [7:0]  first_b     = '0;
  logic [7:0]  second_b    = '0;
  logic        seen_eq     = 1'b0;
  logic        at_start    = 1'b0;
  logic        neg         = 1'b0;
  logic        seen_pt     = 1'b0;
  logic        bad         = 1'b0;
  logic [15:0] int_acc     = '0;
  logic [16:0] frac_acc    = '0;
  logic [2:0]  frac_cnt    = '0;
  gain_cmd_t   expected_cmds[$];
  int          errors      = 0;
  int          checked     = 0;
  int          good_frames = 0;

  function void clear_value();
    at_start = 1'b0;
    neg      = 1'b0;
    seen_pt  = 1'b0;
    bad      = 1'b0;
    int_acc  = '0;
    frac_acc = '0;
    frac_cnt = '0;
  endfunction

  function void clear_frame();
    byte_idx = '0;
    first_b  = '0;
    second_b = '0;
    seen_eq  = 1'b0;
    clear_value();
  endfunction

  // Map the two leading bytes to kind*3+loop, or none
  function logic [3:0] target_of();
    logic [3:0] kind;
    logic [3:0] lp;
    case (first_b)
      CH_P:    kind = 4'd0;
      CH_I:    kind = 4'd1;
      CH_D:    kind = 4'd2;
      default: return TARGET_NONE;
    endcase
    case (second_b)
      CH_1:    lp = 4'd0;
      CH_2:    lp = 4'd1;
      CH_3:    lp = 4'd2;
      default: return TARGET_NONE;
    endcase
    return kind * 4'd3 + lp;
  endfunction

  // Build signed Q16.16 from the decimal parts, rounding the fraction half up
  function logic signed [31:0] q16_value();
    logic [63:0] den;
    logic [63:0] fr;
    logic [63:0] mag;
    den = 64'd1;
    fr  = 64'd0;
    for (int k = 0; k < int'(frac_cnt); k++) den = den * 64'd10;
    if (frac_cnt != 0) fr = ((64'(frac_acc) << 17) + den) / (den << 1);
    mag = (64'(int_acc) << 16) + fr;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Fold one byte after '=' into the value
  function void take_value_byte(logic [7:0] b);
    logic        first;
    logic [19:0] nxt;
    first    = at_start;
    at_start = 1'b0;
    if (b == CH_MINUS && first) begin
      neg = 1'b1;
    end else if (b == CH_POINT) begin
      if (seen_pt) bad = 1'b1;
      else seen_pt = 1'b1;
    end else if (b >= CH_0 && b <= CH_9) begin
      if (seen_pt) begin
        if (int'(frac_cnt) < MAX_FRAC_DIGITS) begin
          frac_acc = 17'(frac_acc * 17'd10 + 17'(b - CH_0));
          frac_cnt = frac_cnt + 3'd1;
        end
      end else begin
        nxt = 20'(int_acc) * 20'd10 + 20'(b - CH_0);
        int_acc = (nxt > 20'd65535) ? 16'hFFFF : nxt[15:0];
      end
    end else begin
      bad = 1'b1;
    end
  endfunction

  // Advance the parser by one accepted byte and queue any command it finishes
  function void note_byte(logic [7:0] b);
    gain_cmd_t c;
    logic      ok;
    if (byte_idx == 0) first_b = b;
    else if (byte_idx == 1) second_b = b;
    if (b == CH_BANG) begin
      ok          = seen_eq && !bad;
      c.target    = target_of();
      c.value     = ok ? q16_value() : 32'sd0;
      c.format_ok = ok;
      expected_cmds.push_back(c);
      clear_frame();
      return;
    end
    if (b == CH_EQ) begin
      clear_value();
      seen_eq  = 1'b1;
      at_start = 1'b1;
    end else if (seen_eq) begin
      take_value_byte(b);
    end
    if (int'(byte_idx) + 1 >= FRAME_BYTES) begin
      c.target    = target_of();
      c.value     = 32'sd0;
      c.format_ok = 1'b0;
      expected_cmds.push_back(c);
      clear_frame();
    end else begin
      byte_idx = byte_idx + 7'd1;
    end
  endfunction

  // Compare one accepted result with the oldest queued command
  function void check_result(logic [3:0] t, logic signed [31:0] v, logic ok);
    gain_cmd_t c;
    if (expected_cmds.size() == 0) begin
      $error("unexpected result: target %0d value %0d format_ok %0b", t, v, ok);
      errors++;
      return;
    end
    c = expected_cmds.pop_front();
    checked++;
    if (c.format_ok) good_frames++;
    if (t !== c.target) begin
      $error("target mismatch: expected %0d, actual %0d", c.target, t);
      errors++;
    end
    if (v !== c.value) begin
      $error("value mismatch: expected %0d, actual %0d", c.value, v);
      errors++;
    end
    if (ok !== c.format_ok) begin
      $error("format_ok mismatch: expected %0b, actual %0b", c.format_ok, ok);
      errors++;
    end
  endfunction

  function int pending();
    return expected_cmds.size();
  endfunction
endclass

module ascii_gain_command_parser_tb;
  localparam int ITEM_COUNT    = 1650;
  localparam int QUIET_FROM    = 1400;
  localparam int PRESSURE_AT   = 500;
  localparam int PRESSURE_LEN  = 300;
  localparam int CYCLE_LIMIT   = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  agcp_byte_if rx_if ();
  agcp_res_if  res_if ();

  ascii_gain_command_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  gain_cmd_scoreboard sb = new;

  logic [7:0] frame_q[$];
  bit         idling_on     = 1'b1;
  bit         hold_request  = 1'b0;
  int         sent_count    = 0;
  int         overlong_cnt  = 0;
  int         cycle_count   = 0;

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("simulation failed");
    $finish;
  end

  // Result side: check accepted items, stall in random bursts and once for a long stretch
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    res_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.target, res_if.value, res_if.format_ok);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_cnt = PRESSURE_LEN;
        res_if.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt--;
        if (hold_cnt == 0) res_if.ready <= 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 7);
        res_if.ready <= 1'b0;
      end
    end
  end

  // Offer one byte, with an optional idle burst first, and wait until it is taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    sb.note_byte(b);
    sent_count++;
    if (sent_count == PRESSURE_AT) hold_request = 1'b1;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_frame_q();
    foreach (frame_q[i]) send_byte(frame_q[i]);
    frame_q.delete();
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_0 + 8'($urandom_range(0, 9));
  endfunction

  // Any byte that the value grammar rejects
  function automatic logic [7:0] rand_illegal();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while ((b >= CH_0 && b <= CH_9) || b == CH_POINT || b == CH_MINUS ||
               b == CH_BANG || b == CH_EQ);
    return b;
  endfunction

  function automatic logic [7:0] rand_no_bang();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(0, 255));
    end while (b == CH_BANG);
    return b;
  endfunction

  // Append '=' and a number with random sign, digits and fraction
  function automatic void add_value();
    int n_int;
    int n_frac;
    frame_q.push_back(CH_EQ);
    if ($urandom_range(0, 2) == 0) frame_q.push_back(CH_MINUS);
    n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
    repeat (n_int) frame_q.push_back(rand_digit());
    if ($urandom_range(0, 3) != 0) begin
      frame_q.push_back(CH_POINT);
      n_frac = $urandom_range(0, 8);
      repeat (n_frac) frame_q.push_back(rand_digit());
    end
  endfunction

  // Build one random frame: mostly well formed, the rest broken or noise
  function automatic void build_frame();
    int mode;
    int n;
    mode = $urandom_range(0, 99);
    if (mode >= 96) begin
      repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 2))
        0:       frame_q.push_back(CH_P);
        1:       frame_q.push_back(CH_I);
        default: frame_q.push_back(CH_D);
      endcase
      frame_q.push_back(CH_1 + 8'($urandom_range(0, 2)));
    end else begin
      frame_q.push_back(rand_no_bang());
      frame_q.push_back(rand_no_bang());
    end
    repeat ($urandom_range(0, 2)) frame_q.push_back(8'h61 + 8'($urandom_range(0, 25)));
    if (mode < 70) begin
      add_value();
      if ($urandom_range(0, 7) == 0) add_value();
    end else if (mode < 84) begin
      add_value();
      case ($urandom_range(0, 2))
        0: begin
          frame_q.push_back(CH_POINT);
          frame_q.push_back(rand_digit());
          frame_q.push_back(CH_POINT);
        end
        1: begin
          frame_q.push_back(rand_digit());
          frame_q.push_back(CH_MINUS);
        end
        default: frame_q.push_back(rand_illegal());
      endcase
      repeat ($urandom_range(0, 2)) frame_q.push_back(rand_digit());
    end else if (mode < 91) begin
      repeat ($urandom_range(0, 4)) frame_q.push_back(rand_digit());
    end else begin
      // Run to the frame length limit, or stop exactly at it with '!'
      n = FRAME_BYTES - 1 + $urandom_range(0, 10) - frame_q.size();
      if (n > FRAME_BYTES - 1 - frame_q.size()) overlong_cnt++;
      repeat (n) frame_q.push_back(rand_no_bang());
    end
    frame_q.push_back(CH_BANG);
  endfunction

  // Stimulus
  initial begin
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: negative saturation, fraction carry with extra digits, empty values
    send_text("D3=-99999!");
    send_text("I2=.999999!");
    send_text("=!");
    send_text("P1=-!");

    // Random frames; quiet handshakes at the end
    while (sent_count < ITEM_COUNT) begin
      idling_on = (sent_count < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      build_frame();
      send_frame_q();
    end
    rx_if.valid <= 1'b0;

    // Drain and let the pipeline settle
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("sent %0d bytes with %0d overlong frames; checked %0d commands, %0d well formed",
             sent_count, overlong_cnt, sb.checked, sb.good_frames);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
